// File: src/dns_query_validator_defines.svh
// assertion helpers for the dns query validator
`ifndef DNS_QUERY_VALIDATOR_DEFINES_SVH
`define DNS_QUERY_VALIDATOR_DEFINES_SVH

// a condition that implies another in the next cycle
`define DQV_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("dqv check failed");

// a condition that must hold at every edge
`define DQV_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("dqv check failed");

`endif

// File: src/dqv_pkg.sv
`default_nettype none
package dqv_pkg;

   localparam int MAX_PACKET_BYTES = 512;

   typedef enum logic [2:0] {
      PH_HDR   = 3'd0,
      PH_NLEN  = 3'd1,
      PH_NLAB  = 3'd2,
      PH_QTAIL = 3'd3,
      PH_OPT   = 3'd4,
      PH_RDATA = 3'd5,
      PH_DONE  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      V_NOERROR = 2'd0,
      V_FORMERR = 2'd1,
      V_NOTIMP  = 2'd2,
      V_BADVERS = 2'd3
   } verdict_type;

   localparam logic [15:0] UDP_DEFAULT = 16'd512;
   localparam logic [15:0] OPT_TYPE    = 16'd41;
   localparam int          MIN_PACKET  = 17;

   // msb first, so drop lands in bit 0
   typedef struct packed {
      logic [15:0] udp_size;
      logic        dnssec_ok;
      logic        has_opt;
      logic [8:0]  question_length;
      logic [5:0]  last_label_len;
      logic [8:0]  label_offset;
      logic [6:0]  label_count;
      logic [15:0] query_type;
      logic [1:0]  copied_flags;
      logic [15:0] query_id;
      logic [1:0]  verdict;
      logic        drop;
   } result_type;

endpackage
`default_nettype wire

// File: src/dns_query_validator.sv
`default_nettype none
// dns query validator: takes a query packet one byte per request on the req_
// stream (tlast on the final byte) and gives one verdict per packet on rsp_,
// in the cycle after the final byte is taken. one byte is accepted every
// cycle; the parse is a small byte-wise state machine feeding a one-entry
// result register, and req_tready only drops while a result waits and
// rsp_tready is low. packets longer than MAX_PACKET_BYTES (512, a package
// constant) are dropped. csr_ writes set the lower clamp of the edns udp size
// and must only happen while the block is idle.
`include "dns_query_validator_defines.svh"
module dns_query_validator (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // pkt_byte
   input  wire         req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // drop, verdict, query_id, copied_flags, query_type, label_count,
   // label_offset, last label length, question_length, has_opt, dnssec_ok,
   // udp_size; 86 bits padded to 88
   output logic [87:0] rsp_tdata,
   input  wire         csr_we,
   input  wire  [15:0] csr_wdata
);
   import dqv_pkg::*;

   localparam int PW = $clog2(MAX_PACKET_BYTES + 2);

   logic [15:0] min_udp_ff;
   logic [PW-1:0] pos_ff, pos_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] shift_ff, shift_in, id_ff, id_in, flags_ff, flags_in;
   logic [5:0]  left_ff, left_in;
   logic [8:0]  total_ff, total_in;
   logic [6:0]  labels_ff, labels_in;
   logic [9:0]  llpos_ff, llpos_in;
   logic [15:0] qtype_ff, qtype_in, skip_ff, skip_in;
   logic [7:0]  ver_ff, ver_in;
   logic [1:0]  verdict_ff, verdict_in;
   logic [2:0]  oflags_ff, oflags_in;
   logic [15:0] udp_ff, udp_in;
   logic [8:0]  qlen_ff, qlen_in;
   logic        dec_ff, dec_in;
   logic        rv_ff;
   result_type  res_ff, res_in;

   logic        take, fin;
   logic [9:0]  p10, idx;
   logic [7:0]  b;
   logic [8:0]  tsum;
   logic [PW-1:0] len;
   logic [1:0]  v;
   logic        name_ok;

   assign req_tready = !rv_ff || rsp_tready;
   assign take = req_tvalid && req_tready;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {2'b00, res_ff};
   assign b = req_tdata;
   assign p10 = 10'(pos_ff);

   always_comb begin
      pos_in = pos_ff; phase_in = phase_ff; shift_in = shift_ff; id_in = id_ff;
      flags_in = flags_ff; left_in = left_ff; total_in = total_ff;
      labels_in = labels_ff; llpos_in = llpos_ff; qtype_in = qtype_ff;
      skip_in = skip_ff; ver_in = ver_ff; verdict_in = verdict_ff;
      oflags_in = oflags_ff; udp_in = udp_ff; qlen_in = qlen_ff; dec_in = dec_ff;
      idx = '0; tsum = '0;
      // per-byte parse, skipped once a verdict is set or past capacity
      if (32'(pos_ff) < MAX_PACKET_BYTES && !dec_ff) begin
         case (phase_ff)
            PH_HDR: begin
               if (p10 < 10'd2) id_in = {id_ff[7:0], b};
               else if (p10 < 10'd4) flags_in = {flags_ff[7:0], b};
               else if (p10 == 10'd5) begin
                  if (b != 8'd1) shift_in = 16'd1;
               end else if (p10 == 10'd11) begin
                  if (b > 8'd1) shift_in = 16'd1;
               end else if (b != 8'd0) shift_in = 16'd1;
               if (p10 == 10'd11) begin
                  if (shift_in != 16'd0 || flags_ff[3:0] != 4'd0) begin
                     verdict_in = V_FORMERR; dec_in = 1'b1;
                  end else if (flags_ff[14:11] != 4'd0) begin
                     verdict_in = V_NOTIMP; dec_in = 1'b1;
                  end else phase_in = PH_NLEN;
                  shift_in = '0;
               end
            end
            PH_NLEN: begin
               if (b == 8'd0) begin
                  if (labels_ff == 7'd0) llpos_in = p10;
                  phase_in = PH_QTAIL;
                  shift_in = '0;
               end else begin
                  if (labels_ff != 7'd127) labels_in = labels_ff + 7'd1;
                  llpos_in = p10 + 10'd1;
                  if (b[7:6] != 2'b00) begin
                     verdict_in = V_FORMERR; dec_in = 1'b1;
                  end else begin
                     tsum = total_ff + 9'(b) + 9'd1;
                     total_in = tsum;
                     if (tsum > 9'd255) begin
                        verdict_in = V_FORMERR; dec_in = 1'b1;
                     end else begin
                        left_in = b[5:0];
                        phase_in = PH_NLAB;
                     end
                  end
               end
            end
            PH_NLAB: begin
               if (left_ff != 6'd0) left_in = left_ff - 6'd1;
               if (left_in == 6'd0) phase_in = PH_NLEN;
            end
            PH_QTAIL: begin
               idx = p10 - 10'd13 - 10'(total_ff);
               shift_in = {shift_ff[7:0], b};
               if (idx == 10'd1) skip_in = shift_in;
               if (idx == 10'd3) begin
                  qtype_in = skip_ff;
                  qlen_in = 9'(p10 + 10'd1 - 10'd12);
                  skip_in = '0;
                  if ((skip_ff >= 16'd128 && skip_ff < 16'd255) || shift_in != 16'd1)
                  begin
                     verdict_in = V_NOTIMP; dec_in = 1'b1;
                  end else phase_in = PH_OPT;
                  shift_in = '0;
               end
            end
            PH_OPT: begin
               idx = p10 - 10'd12 - 10'(qlen_ff);
               shift_in = {shift_ff[7:0], b};
               if (idx == 10'd0 && b != 8'd0) begin
                  verdict_in = V_FORMERR; dec_in = 1'b1;
               end else if (idx == 10'd2 && shift_in != OPT_TYPE) begin
                  verdict_in = V_FORMERR; dec_in = 1'b1;
               end else if (idx == 10'd4) skip_in = shift_in;
               else if (idx == 10'd6) ver_in = b;
               else if (idx == 10'd8) begin
                  if (shift_in[15]) oflags_in[2] = 1'b1;
               end else if (idx == 10'd10) begin
                  udp_in = (skip_ff < min_udp_ff) ? min_udp_ff : skip_ff;
                  skip_in = shift_in;
                  if (shift_in == 16'd0) begin
                     oflags_in = {oflags_ff[2], oflags_ff[2], 1'b1};
                     if (ver_ff != 8'd0) begin
                        verdict_in = V_BADVERS; dec_in = 1'b1;
                     end else phase_in = PH_DONE;
                  end else phase_in = PH_RDATA;
               end
            end
            PH_RDATA: begin
               if (skip_ff != 16'd0) skip_in = skip_ff - 16'd1;
               if (skip_in == 16'd0) begin
                  oflags_in = {oflags_ff[2], oflags_ff[2], 1'b1};
                  if (ver_ff != 8'd0) begin
                     verdict_in = V_BADVERS; dec_in = 1'b1;
                  end else phase_in = PH_DONE;
               end
            end
            default: begin
               verdict_in = V_FORMERR; dec_in = 1'b1;
            end
         endcase
      end
      if (32'(pos_ff) <= MAX_PACKET_BYTES) pos_in = pos_ff + PW'(1);
   end

   // verdict built from the updated state on the final byte
   always_comb begin
      len = pos_in;
      res_in = '0;
      if (dec_in) v = verdict_in;
      else if (phase_in == PH_DONE) v = V_NOERROR;
      else if (phase_in == PH_OPT && 32'(len) == 32'(qlen_in) + 12) v = V_NOERROR;
      else v = V_FORMERR;
      name_ok = (phase_in >= PH_QTAIL);
      if (32'(len) < MIN_PACKET || 32'(len) > MAX_PACKET_BYTES || flags_in[15]) begin
         res_in.drop = 1'b1;
      end else begin
         res_in.verdict = v;
         res_in.query_id = id_in;
         res_in.copied_flags = {flags_in[8], flags_in[4]};
         res_in.query_type = qtype_in;
         res_in.label_count = labels_in;
         res_in.label_offset = name_ok ? llpos_in[8:0] : 9'd0;
         res_in.last_label_len = name_ok ?
            6'(10'd12 + 10'(total_in) - llpos_in) : 6'd0;
         res_in.question_length = qlen_in;
         res_in.has_opt = oflags_in[0];
         res_in.dnssec_ok = oflags_in[1];
         res_in.udp_size = udp_in;
      end
   end

   assign fin = take && req_tlast;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_udp_ff <= UDP_DEFAULT;
      end else if (csr_we) begin
         min_udp_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || fin) begin
         pos_ff <= '0; phase_ff <= PH_HDR; shift_ff <= '0; id_ff <= '0;
         flags_ff <= '0; left_ff <= '0; total_ff <= '0; labels_ff <= '0;
         llpos_ff <= '0; qtype_ff <= '0; skip_ff <= '0; ver_ff <= '0;
         verdict_ff <= '0; oflags_ff <= '0; udp_ff <= UDP_DEFAULT;
         qlen_ff <= '0; dec_ff <= 1'b0;
      end else if (take) begin
         pos_ff <= pos_in; phase_ff <= phase_in; shift_ff <= shift_in;
         id_ff <= id_in; flags_ff <= flags_in; left_ff <= left_in;
         total_ff <= total_in; labels_ff <= labels_in; llpos_ff <= llpos_in;
         qtype_ff <= qtype_in; skip_ff <= skip_in; ver_ff <= ver_in;
         verdict_ff <= verdict_in; oflags_ff <= oflags_in; udp_ff <= udp_in;
         qlen_ff <= qlen_in; dec_ff <= dec_in;
      end
   end

   // result register, refilled while the old result leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (fin) begin
         rv_ff <= 1'b1;
      end else if (rsp_tready) begin
         rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin) res_ff <= res_in;
   end

   // a final byte always yields a result next cycle
   `DQV_NEXT(a_fin_result, fin, rv_ff)
   // a dropped packet reports a zero (noerror) verdict
   `DQV_ALWAYS(a_drop_clean, !(rv_ff && res_ff.drop) || res_ff.verdict == V_NOERROR)
   // parse state restarts after a final byte
   `DQV_NEXT(a_restart, fin, pos_ff == '0 && !dec_ff)

endmodule
`default_nettype wire

// File: tb/sv/tb_dns_query_validator.sv
`default_nettype none
module tb_dns_query_validator;
   import dqv_pkg::*;

   localparam int PKT_MAX    = MAX_PACKET_BYTES;
   localparam int WDOG_LIMIT = 5000;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } pkt_byte_type;

   typedef struct {
      logic        drop;
      logic [1:0]  verdict;
      logic [15:0] query_id;
      logic [1:0]  copied_flags;
      logic [15:0] query_type;
      logic [6:0]  label_count;
      logic [8:0]  label_offset;
      logic [5:0]  last_label_len;
      logic [8:0]  question_length;
      logic        has_opt;
      logic        dnssec_ok;
      logic [15:0] udp_size;
   } verdict_rec_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [87:0]  rsp_tdata;
   logic         csr_we = 1'b0;
   logic [15:0]  csr_wdata = '0;

   // fields from bit 0 up: drop, verdict, query_id, copied_flags, query_type,
   // label_count, label_offset, last label length, question_length, has_opt,
   // dnssec_ok, udp_size
   dns_query_validator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   pkt_byte_type    pending_bytes[$];
   verdict_rec_type expected_verdicts[$];
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  req_fire = 1'b0;
   int  mismatches = 0;
   int  quiet_cycles = 0;

   // predictor state, parse fields cleared after every final byte
   int unsigned  clamp_min = 512;
   int unsigned  pos_cnt, shift_acc, id_q, flags_q, lab_left, name_len, lab_cnt;
   int unsigned  lab_pos, qtype_q, skip_cnt, edns_ver, qlen_q, udp_q;
   logic [2:0]   opt_bits;
   verdict_type  verd_q;
   phase_type    ph;
   bit           settled;

   function automatic void put_byte(ref logic [7:0] q[$], input logic [7:0] v);
      q.insert(q.size(), v);
   endfunction

   function automatic void clear_parse();
      pos_cnt = 0; ph = PH_HDR; shift_acc = 0; id_q = 0; flags_q = 0;
      lab_left = 0; name_len = 0; lab_cnt = 0; lab_pos = 0; qtype_q = 0;
      skip_cnt = 0; edns_ver = 0; verd_q = V_NOERROR; opt_bits = '0;
      udp_q = 512; qlen_q = 0; settled = 1'b0;
   endfunction

   function automatic void settle(verdict_type v);
      verd_q = v;
      settled = 1'b1;
   endfunction

   function automatic void finish_opt();
      opt_bits[0] = 1'b1;
      if (opt_bits[2]) opt_bits[1] = 1'b1;
      if (edns_ver > 0) settle(V_BADVERS);
      else ph = PH_DONE;
   endfunction

   function automatic void parse_byte(int unsigned b, int unsigned pos);
      int unsigned idx;
      if (settled) return;
      case (ph)
         PH_HDR: begin
            if (pos <= 1) id_q = ((id_q << 8) | b) & 'hffff;
            else if (pos <= 3) flags_q = ((flags_q << 8) | b) & 'hffff;
            else if (pos == 5) begin
               if (b != 1) shift_acc = 1;
            end else if (pos == 11) begin
               if (b > 1) shift_acc = 1;
            end else if (b != 0) shift_acc = 1;
            if (pos == 11) begin
               // header counts and rcode first, opcode second
               if (shift_acc != 0 || (flags_q & 'h000f) != 0) settle(V_FORMERR);
               else if (((flags_q >> 11) & 'hf) != 0) settle(V_NOTIMP);
               else ph = PH_NLEN;
               shift_acc = 0;
            end
         end
         PH_NLEN: begin
            if (b == 0) begin
               if (lab_cnt == 0) lab_pos = pos;
               ph = PH_QTAIL;
               shift_acc = 0;
            end else begin
               if (lab_cnt < 127) lab_cnt++;
               lab_pos = pos + 1;
               if ((b & 'hc0) != 0) settle(V_FORMERR);
               else begin
                  name_len += b + 1;
                  if (name_len > 255) settle(V_FORMERR);
                  else begin
                     lab_left = b;
                     ph = PH_NLAB;
                  end
               end
            end
         end
         PH_NLAB: begin
            if (lab_left > 0) lab_left--;
            if (lab_left == 0) ph = PH_NLEN;
         end
         PH_QTAIL: begin
            idx = pos - 13 - name_len;
            shift_acc = ((shift_acc << 8) | b) & 'hffff;
            if (idx == 1) skip_cnt = shift_acc;
            if (idx == 3) begin
               qtype_q = skip_cnt;
               qlen_q = (pos + 1 - 12) & 'h1ff;
               skip_cnt = 0;
               // meta types and any class but IN
               if (qtype_q >= 128 && qtype_q < 255) settle(V_NOTIMP);
               else if (shift_acc != 1) settle(V_NOTIMP);
               else ph = PH_OPT;
               shift_acc = 0;
            end
         end
         PH_OPT: begin
            idx = pos - 12 - qlen_q;
            shift_acc = ((shift_acc << 8) | b) & 'hffff;
            if (idx == 0 && b != 0) settle(V_FORMERR);
            else if (idx == 2 && shift_acc != 41) settle(V_FORMERR);
            else if (idx == 4) skip_cnt = shift_acc;
            else if (idx == 6) edns_ver = b;
            else if (idx == 8) begin
               if ((shift_acc & 'h8000) != 0) opt_bits[2] = 1'b1;
            end else if (idx == 10) begin
               udp_q = (skip_cnt < clamp_min) ? clamp_min : skip_cnt;
               skip_cnt = shift_acc;
               if (skip_cnt == 0) finish_opt();
               else ph = PH_RDATA;
            end
         end
         PH_RDATA: begin
            if (skip_cnt > 0) skip_cnt--;
            if (skip_cnt == 0) finish_opt();
         end
         default: settle(V_FORMERR);
      endcase
   endfunction

   function automatic bit predict_verdict(logic [7:0] b, logic last,
                                          output verdict_rec_type r);
      int unsigned len;
      bit name_done;
      r = '{default: '0};
      if (pos_cnt < PKT_MAX) parse_byte(32'(b), pos_cnt);
      if (pos_cnt <= PKT_MAX) pos_cnt++;
      if (!last) return 1'b0;
      len = pos_cnt;
      if (len < 17 || len > PKT_MAX || flags_q[15]) begin
         r.drop = 1'b1;
      end else begin
         if (settled) r.verdict = verd_q;
         else if (ph == PH_DONE) r.verdict = V_NOERROR;
         else if (ph == PH_OPT && len == 12 + qlen_q) r.verdict = V_NOERROR;
         else r.verdict = V_FORMERR;
         name_done = (ph >= PH_QTAIL);
         r.query_id = 16'(id_q);
         r.copied_flags = {flags_q[8], flags_q[4]};
         r.query_type = 16'(qtype_q);
         r.label_count = 7'(lab_cnt);
         r.label_offset = name_done ? 9'(lab_pos) : 9'd0;
         r.last_label_len = name_done ? 6'(12 + name_len - lab_pos) : 6'd0;
         r.question_length = 9'(qlen_q);
         r.has_opt = opt_bits[0];
         r.dnssec_ok = opt_bits[1];
         r.udp_size = 16'(udp_q);
      end
      clear_parse();
      return 1'b1;
   endfunction

   function automatic void field_check(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch in %s: expected %0d, got %0d", name, exp_v, act_v);
      end
   endfunction

   // monitor and predictor, both sampled at the rising edge
   always @(posedge clock) begin
      verdict_rec_type exp_r, got_r;
      bit produced;
      req_fire = req_tvalid && req_tready && !reset;
      if (reset) begin
         clear_parse();
         clamp_min = 512;
         quiet_cycles = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_r.drop = rsp_tdata[0];
            got_r.verdict = rsp_tdata[2:1];
            got_r.query_id = rsp_tdata[18:3];
            got_r.copied_flags = rsp_tdata[20:19];
            got_r.query_type = rsp_tdata[36:21];
            got_r.label_count = rsp_tdata[43:37];
            got_r.label_offset = rsp_tdata[52:44];
            got_r.last_label_len = rsp_tdata[58:53];
            got_r.question_length = rsp_tdata[67:59];
            got_r.has_opt = rsp_tdata[68];
            got_r.dnssec_ok = rsp_tdata[69];
            got_r.udp_size = rsp_tdata[85:70];
            if (expected_verdicts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("verdict with none expected");
            end else begin
               exp_r = expected_verdicts.pop_front();
               field_check("drop", 32'(exp_r.drop), 32'(got_r.drop));
               field_check("verdict", 32'(exp_r.verdict), 32'(got_r.verdict));
               field_check("query_id", 32'(exp_r.query_id), 32'(got_r.query_id));
               field_check("copied_flags", 32'(exp_r.copied_flags),
                           32'(got_r.copied_flags));
               field_check("query_type", 32'(exp_r.query_type), 32'(got_r.query_type));
               field_check("label_count", 32'(exp_r.label_count),
                           32'(got_r.label_count));
               field_check("label_offset", 32'(exp_r.label_offset),
                           32'(got_r.label_offset));
               field_check("last_label_len", 32'(exp_r.last_label_len),
                           32'(got_r.last_label_len));
               field_check("question_length", 32'(exp_r.question_length),
                           32'(got_r.question_length));
               field_check("has_opt", 32'(exp_r.has_opt), 32'(got_r.has_opt));
               field_check("dnssec_ok", 32'(exp_r.dnssec_ok), 32'(got_r.dnssec_ok));
               field_check("udp_size", 32'(exp_r.udp_size), 32'(got_r.udp_size));
            end
         end
         if (req_fire) begin
            produced = predict_verdict(req_tdata, req_tlast, exp_r);
            if (produced) expected_verdicts.insert(expected_verdicts.size(), exp_r);
         end
         if (csr_we) clamp_min = 32'(csr_wdata);
         // watchdog on cycles with no handshake at all
         if (req_fire || (rsp_tvalid && rsp_tready) || csr_we) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // driver: inputs move on the falling edge
   always @(negedge clock) begin
      pkt_byte_type nb;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_fire) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nb = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= nb.data;
               req_tlast <= nb.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // well-formed query: header, name, qtype/qclass, optional opt record;
   // a negative maxlen asks for labels of exactly that length
   function automatic void compose_query(ref logic [7:0] p[$], input int nlab, int maxlen,
                                         int qt, int qc, int with_opt, int ver,
                                         int do_bit, int rdlen, int usz);
      logic [15:0] id_v, fl_v;
      int len;
      p.delete();
      id_v = 16'($urandom);
      fl_v = 16'($urandom) & 16'h07f0;
      put_byte(p, id_v[15:8]); put_byte(p, id_v[7:0]);
      put_byte(p, fl_v[15:8]); put_byte(p, fl_v[7:0]);
      put_byte(p, 8'd0); put_byte(p, 8'd1);
      repeat (4) put_byte(p, 8'd0);
      put_byte(p, 8'd0); put_byte(p, 8'(with_opt != 0));
      for (int i = 0; i < nlab; i++) begin
         len = (maxlen < 0) ? -maxlen : int'($urandom_range(1, maxlen));
         put_byte(p, 8'(len));
         repeat (len) put_byte(p, 8'($urandom));
      end
      put_byte(p, 8'd0);
      put_byte(p, 8'(qt >> 8)); put_byte(p, 8'(qt));
      put_byte(p, 8'(qc >> 8)); put_byte(p, 8'(qc));
      if (with_opt != 0) begin
         put_byte(p, 8'd0); put_byte(p, 8'd0); put_byte(p, 8'd41);
         put_byte(p, 8'(usz >> 8)); put_byte(p, 8'(usz));
         put_byte(p, 8'($urandom)); put_byte(p, 8'(ver));
         put_byte(p, {do_bit != 0, 7'($urandom)}); put_byte(p, 8'($urandom));
         put_byte(p, 8'(rdlen >> 8)); put_byte(p, 8'(rdlen));
         repeat (rdlen) put_byte(p, 8'($urandom));
      end
   endfunction

   function automatic void queue_packet(ref logic [7:0] p[$]);
      foreach (p[i]) pending_bytes.insert(pending_bytes.size(), '{p[i], i == p.size() - 1});
   endfunction

   function automatic int random_qtype();
      case ($urandom_range(3))
         0: return int'($urandom_range(128, 255));
         1: return int'($urandom_range(65535));
         default: return int'($urandom_range(127));
      endcase
   endfunction

   task automatic wait_idle();
      while (pending_bytes.size() > 0 || req_tvalid || expected_verdicts.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_clamp(logic [15:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [7:0] p[$];
      int sent, mode, cut;
      clear_parse();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: minimum packet with the root name
      compose_query(p, 0, 1, 1, 1, 0, 0, 0, 0, 0); queue_packet(p);
      // one byte short
      void'(p.pop_back()); queue_packet(p);
      // response bit set
      compose_query(p, 2, 8, 1, 1, 0, 0, 0, 0, 0); p[2] |= 8'h80; queue_packet(p);
      // nonzero rcode
      compose_query(p, 1, 5, 1, 1, 0, 0, 0, 0, 0); p[3] |= 8'h03; queue_packet(p);
      // opcode other than query
      compose_query(p, 1, 5, 1, 1, 0, 0, 0, 0, 0); p[2] |= 8'h28; queue_packet(p);
      // two questions, then two additional records
      compose_query(p, 1, 5, 1, 1, 0, 0, 0, 0, 0); p[5] = 8'd2; queue_packet(p);
      compose_query(p, 1, 5, 1, 1, 0, 0, 0, 0, 0); p[11] = 8'd2; queue_packet(p);
      // compression pointer in the name
      compose_query(p, 1, 5, 1, 1, 0, 0, 0, 0, 0); p[12] = 8'hc0; queue_packet(p);
      // longest labels and a name over 255 bytes
      compose_query(p, 3, -63, 28, 1, 0, 0, 0, 0, 0); queue_packet(p);
      compose_query(p, 5, -63, 1, 1, 0, 0, 0, 0, 0); queue_packet(p);
      // meta type, the any type, chaos class, all-ones type
      compose_query(p, 1, 4, 200, 1, 0, 0, 0, 0, 0); queue_packet(p);
      compose_query(p, 1, 4, 255, 1, 0, 0, 0, 0, 0); queue_packet(p);
      compose_query(p, 1, 4, 1, 3, 0, 0, 0, 0, 0); queue_packet(p);
      compose_query(p, 1, 4, 'hffff, 1, 0, 0, 0, 0, 0); queue_packet(p);
      // edns: bad version, dnssec ok, option data, small and large sizes
      compose_query(p, 1, 4, 1, 1, 1, 1, 0, 0, 4096); queue_packet(p);
      compose_query(p, 1, 4, 48, 1, 1, 0, 1, 0, 100); queue_packet(p);
      compose_query(p, 2, 6, 1, 1, 1, 0, 1, 4, 'hffff); queue_packet(p);
      // packet ends inside the option data
      void'(p.pop_back()); queue_packet(p);
      // opt owner not the root, wrong record type
      compose_query(p, 0, 1, 1, 1, 1, 0, 0, 0, 1232); p[17] = 8'd1; queue_packet(p);
      compose_query(p, 0, 1, 1, 1, 1, 0, 0, 0, 1232); p[19] = 8'd40;
      queue_packet(p);
      // trailing byte after the question
      compose_query(p, 1, 3, 1, 1, 0, 0, 0, 0, 0); put_byte(p, 8'hff); queue_packet(p);
      // ends inside the name and inside qtype
      compose_query(p, 2, 9, 1, 1, 0, 0, 0, 0, 0);
      p = p[0:p.size() - 8]; queue_packet(p);
      compose_query(p, 1, -4, 1, 1, 0, 0, 0, 0, 0);
      p = p[0:p.size() - 4]; queue_packet(p);
      // over capacity
      compose_query(p, 1, 4, 1, 1, 0, 0, 0, 0, 0);
      while (p.size() < PKT_MAX + 3) put_byte(p, 8'($urandom));
      queue_packet(p);

      for (int phase_no = 0; phase_no < 4; phase_no++) begin
         wait_idle();
         case (phase_no)
            0: write_clamp(16'd0);
            1: write_clamp(16'hffff);
            2: write_clamp(16'($urandom));
            default: write_clamp(16'd512);
         endcase
         send_idle_pct = (phase_no == 1 || phase_no == 3) ? 60 : 0;
         recv_stall_pct = (phase_no == 2 || phase_no == 3) ? 60 : 0;
         if (phase_no == 3) begin
            send_idle_pct = 16;
            recv_stall_pct = 16;
         end
         sent = 0;
         while (sent < 120) begin
            compose_query(p, $urandom_range(0, 4), ($urandom_range(7) == 0) ? 63 : 10,
                          random_qtype(),
                          ($urandom_range(5) == 0) ? int'($urandom_range(65535)) : 1,
                          $urandom_range(1),
                          ($urandom_range(4) == 0) ? int'($urandom_range(255)) : 0,
                          $urandom_range(1),
                          ($urandom_range(2) == 0) ? int'($urandom_range(8)) : 0,
                          int'($urandom_range(65535)));
            mode = $urandom_range(19);
            if (mode < 11) ;
            else if (mode < 14) p[$urandom_range(p.size() - 1)] = 8'($urandom);
            else if (mode < 17) begin
               cut = $urandom_range(1, p.size() - 1);
               p = p[0:cut - 1];
            end else if (mode < 18) repeat ($urandom_range(1, 3)) put_byte(p, 8'($urandom));
            else if (mode < 19) begin
               p.delete();
               repeat ($urandom_range(1, 40)) put_byte(p, 8'($urandom));
            end else begin
               while (p.size() < PKT_MAX + $urandom_range(0, 4)) put_byte(p, 8'($urandom));
            end
            sent += p.size();
            queue_packet(p);
         end
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_verdicts.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire
